>>> rtl/core/ppse_pkg.sv
`timescale 1ns / 1ps

package ppse_pkg;

	localparam int unsigned MAX_RESULTS = 4;
	localparam int unsigned WIN_HELD    = 3;

	localparam logic [7:0] START_B0       = 8'h00;
	localparam logic [7:0] START_B1       = 8'h00;
	localparam logic [7:0] START_B2       = 8'h01;
	localparam logic [7:0] STREAM_ID_RST  = 8'hBD;
	localparam logic [3:0] FIXED_SKIP_RST = 4'd4;

	localparam logic CFG_STREAM_ID  = 1'b0;
	localparam logic CFG_FIXED_SKIP = 1'b1;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       end_of_stream;
	} in_beat_t;

	typedef struct packed {
		logic [7:0] payload_byte;
		logic       last_of_run;
	} out_beat_t;

	// results of one input item, bytes[0] goes out first
	typedef struct packed {
		logic [MAX_RESULTS-1:0][7:0] bytes;
		logic [2:0]                  count;
	} bundle_t;

endpackage

>>> rtl/core/ppse_in_if.sv
`timescale 1ns / 1ps

interface ppse_in_if;
	logic               valid;
	logic               ready;
	ppse_pkg::in_beat_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

>>> rtl/core/ppse_out_if.sv
`timescale 1ns / 1ps

interface ppse_out_if;
	logic                valid;
	logic                ready;
	ppse_pkg::out_beat_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

>>> rtl/core/ppse_parser.sv
`timescale 1ns / 1ps

module ppse_parser (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               accept,
	input  ppse_pkg::in_beat_t beat,
	input  logic [7:0]         stream_id,
	input  logic [3:0]         fixed_skip,
	output ppse_pkg::bundle_t  bundle
);
	import ppse_pkg::*;

	typedef enum logic [3:0] {
		PH_FILL  = 4'b0001,
		PH_FIXED = 4'b0010,
		PH_LEN   = 4'b0100,
		PH_BODY  = 4'b1000
	} phase_t;

	logic [WIN_HELD-1:0][7:0] win_q, win_d;
	logic [1:0]               fill_q, fill_d;
	logic                     seen_q, seen_d;
	phase_t                   phase_q, phase_d;
	logic [8:0]               skip_q, skip_d, skip_dec;
	logic                     emit, match;
	logic [2:0]               flush_cnt;

	assign match = (win_q[0] == START_B0) && (win_q[1] == START_B1) &&
		(win_q[2] == START_B2) && (beat.data_byte == stream_id);
	assign skip_dec = (skip_q != 9'd0) ? skip_q - 9'd1 : skip_q;

	always_comb begin
		win_d   = win_q;
		fill_d  = fill_q;
		seen_d  = seen_q;
		phase_d = phase_q;
		skip_d  = skip_q;
		emit    = 1'b0;
		case (phase_q)
			PH_FILL: begin
				if (fill_q == 2'd3) begin
					if (match) begin
						seen_d = 1'b1;
						fill_d = 2'd0;
						win_d  = '0;
						if (fixed_skip == 4'd0) begin
							phase_d = PH_LEN;
						end else begin
							phase_d = PH_FIXED;
							skip_d  = {5'd0, fixed_skip};
						end
					end else begin
						// window full, no start code: oldest byte leaves
						emit     = seen_q;
						win_d[0] = win_q[1];
						win_d[1] = win_q[2];
						win_d[2] = beat.data_byte;
					end
				end else begin
					win_d[fill_q] = beat.data_byte;
					fill_d        = fill_q + 2'd1;
				end
			end
			PH_FIXED: begin
				skip_d = skip_dec;
				if (skip_dec == 9'd0) phase_d = PH_LEN;
			end
			PH_LEN: begin
				skip_d  = {1'b0, beat.data_byte} + 9'd1;
				phase_d = PH_BODY;
			end
			PH_BODY: begin
				skip_d = skip_dec;
				if (skip_dec == 9'd0) phase_d = PH_FILL;
			end
			default: phase_d = PH_FILL;
		endcase

		flush_cnt    = beat.end_of_stream ? {1'b0, fill_d} : 3'd0;
		bundle.count = {2'd0, emit} + flush_cnt;
		if (emit) begin
			bundle.bytes = {win_d[2], win_d[1], win_d[0], win_q[0]};
		end else begin
			bundle.bytes = {8'd0, win_d[2], win_d[1], win_d[0]};
		end

		if (beat.end_of_stream) begin
			fill_d  = 2'd0;
			seen_d  = 1'b0;
			phase_d = PH_FILL;
			skip_d  = 9'd0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q  <= 2'd0;
			seen_q  <= 1'b0;
			phase_q <= PH_FILL;
			skip_q  <= 9'd0;
		end else if (accept) begin
			fill_q  <= fill_d;
			seen_q  <= seen_d;
			phase_q <= phase_d;
			skip_q  <= skip_d;
		end
	end

	// bytes are only read below the fill count
	always_ff @(posedge clk) begin
		if (accept) win_q <= win_d;
	end

	a_fixed_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_FIXED |-> skip_q != 9'd0)
		else $error("fixed skip phase with zero count");

	a_body_range: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_BODY |-> (skip_q != 9'd0 && skip_q <= 9'd256))
		else $error("body skip count out of range");

	a_window_empty_in_skip: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q != PH_FILL |-> fill_q == 2'd0)
		else $error("window holds bytes during header skip");

endmodule

>>> rtl/core/ppse_serializer.sv
`timescale 1ns / 1ps

module ppse_serializer (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              load,
	input  ppse_pkg::bundle_t bundle,
	output logic              ready,
	ppse_out_if.source        payload
);
	import ppse_pkg::*;

	logic [MAX_RESULTS-1:0][7:0] pend_q;
	logic [2:0]                  cnt_q;
	logic [1:0]                  idx_q;
	logic                        out_valid_q;
	out_beat_t                   out_q;
	logic                        move;

	assign move  = (cnt_q != 3'd0) && (!out_valid_q || payload.ready);
	assign ready = (cnt_q == 3'd0) || (cnt_q == 3'd1 && move);

	assign payload.valid = out_valid_q;
	assign payload.data  = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q       <= 3'd0;
			idx_q       <= 2'd0;
			out_valid_q <= 1'b0;
		end else begin
			if (load && bundle.count != 3'd0) begin
				cnt_q <= bundle.count;
				idx_q <= 2'd0;
			end else if (move) begin
				cnt_q <= cnt_q - 3'd1;
				idx_q <= idx_q + 2'd1;
			end
			if (move) begin
				out_valid_q <= 1'b1;
			end else if (payload.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load && bundle.count != 3'd0) pend_q <= bundle.bytes;
		if (move) begin
			out_q.payload_byte <= pend_q[idx_q];
			out_q.last_of_run  <= (cnt_q == 3'd1);
		end
	end

	a_load_when_free: assert property (@(posedge clk) disable iff (!arst_n)
		load |-> (cnt_q == 3'd0 || (cnt_q == 3'd1 && move)))
		else $error("bundle loaded over pending bytes");

	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= 3'd4 && ({1'b0, idx_q} + cnt_q) <= 3'd4)
		else $error("pending count out of range");

	a_last_closes: assert property (@(posedge clk) disable iff (!arst_n)
		(move && cnt_q == 3'd1 && !load) |=> cnt_q == 3'd0)
		else $error("pending bytes left after last beat");

endmodule

>>> rtl/core/pes_private_stream_payload_extractor_top.sv
`timescale 1ns / 1ps

// PES header strip for a private stream.
// stream: one input byte per beat (data_byte, end_of_stream), valid/ready.
// payload: extracted bytes, last_of_run set on the final byte caused by
//   one input beat. An input beat may cause zero to four output beats.
// cfg: write port, index 0 = stream_id, index 1 = fixed_skip; write only
//   while the block is idle.
// The first byte caused by an input beat passes the pending bundle register
//   and then the output register before it is valid on payload.
// Throughput: one input beat per cycle while payload accepts and each beat
//   yields at most one byte; a beat yielding more bytes holds input back
//   while the single output register drains the pending result bundle.
// When payload stalls, one held output beat plus one pending bundle are
// buffered; stream ready drops only once both are occupied.
// Reset empties the window, clears header state and skip counter, and loads
// stream_id = 0xBD, fixed_skip = 4. The end_of_stream beat flushes the
// window and returns all stream state to its reset value.

module pes_private_stream_payload_extractor_top (
	input  logic       clk,
	input  logic       arst_n,
	ppse_in_if.sink    stream,
	ppse_out_if.source payload,
	input  logic       cfg_we,
	input  logic       cfg_index,
	input  logic [7:0] cfg_data
);
	import ppse_pkg::*;

	logic [7:0] stream_id_q;
	logic [3:0] fixed_skip_q;
	logic       accept;
	logic       ready;
	bundle_t    bundle;

	assign stream.ready = ready;
	assign accept       = stream.valid && ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stream_id_q  <= STREAM_ID_RST;
			fixed_skip_q <= FIXED_SKIP_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_STREAM_ID:  stream_id_q  <= cfg_data;
				CFG_FIXED_SKIP: fixed_skip_q <= cfg_data[3:0];
				default: ;
			endcase
		end
	end

	ppse_parser u_parser (
		.clk        (clk),
		.arst_n     (arst_n),
		.accept     (accept),
		.beat       (stream.data),
		.stream_id  (stream_id_q),
		.fixed_skip (fixed_skip_q),
		.bundle     (bundle)
	);

	ppse_serializer u_serializer (
		.clk     (clk),
		.arst_n  (arst_n),
		.load    (accept),
		.bundle  (bundle),
		.ready   (ready),
		.payload (payload)
	);

endmodule
